// File: src/mecanum_wheel_mixer_core_assert.svh
// Assertion macros for the mecanum mixer RTL.
// Each use needs clk and rst_n in the scope where it stands.
`ifndef MECANUM_WHEEL_MIXER_CORE_ASSERT_SVH
`define MECANUM_WHEEL_MIXER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWM_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mecanum mixer check failed");

// The expression must hold at every clock edge outside reset.
`define MWM_ASSERT_ALWAYS(label, expr) \
    `MWM_ASSERT_IMPLIES(label, 1'b1, expr)

`endif

// File: src/mwm_pkg.sv
// Shared widths, register codes and item types of the mecanum wheel mixer.
// Depends on nothing; every RTL module uses it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package mwm_pkg;

    localparam int WHEELS      = 4;
    localparam int IN_W        = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int FRAC_BITS   = 12;
    localparam int SUM_W       = IN_W + 1;
    localparam int ROT_W       = IN_W + CFG_W + 1;
    localparam int SP_W        = ROT_W + 1;
    localparam int MAG_W       = 20;
    localparam int QUO_W       = 16;
    localparam int DIV_W       = MAG_W + CFG_W;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_W-1:0] RESET_SPEED_LIMIT   = 16'd100;
    localparam logic [CFG_W-1:0] RESET_ROTATION_GAIN = 16'd7620;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_LIMIT   = 1'b0,
        REG_ROTATION_GAIN = 1'b1
    } cfg_index_t;

    // One classified command: wheel magnitudes, their peak, whether the
    // set must be scaled down to the limit, and the direction bits.
    typedef struct packed {
        logic [WHEELS-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]             peak;
        logic                         scale;
        logic [WHEELS-1:0]            fwd;
    } front_item_t;

    typedef struct packed {
        logic valid;
        logic full;
    } queue_status_t;

endpackage

`default_nettype wire

// File: src/mwm_front.sv
// Front end: accepts commands, works out the four wheel speeds, directions,
// magnitudes and the scaling decision. Depends on mwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mwm_front
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic signed [mwm_pkg::IN_W-1:0]     lateral_speed,
    input  wire logic signed [mwm_pkg::IN_W-1:0]     forward_speed,
    input  wire logic signed [mwm_pkg::IN_W-1:0]     turn_rate,
    input  wire logic        [mwm_pkg::CFG_W-1:0]    speed_limit,
    input  wire logic        [mwm_pkg::CFG_W-1:0]    rotation_gain,
    input  wire mwm_pkg::queue_status_t              q_status,
    output logic                                     push,
    output mwm_pkg::front_item_t                     item
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] vld_reg, vld_next;
    logic              f_en;

    logic signed [mwm_pkg::ROT_W-1:0] rot_reg, rot_next;
    logic signed [mwm_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic signed [mwm_pkg::SUM_W-1:0] dif_reg, dif_next;

    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::SP_W-1:0]  sp_reg, sp_next;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::SP_W-1:0]  abs_sp;
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0] mag_reg, mag_next;
    logic [mwm_pkg::WHEELS-1:0]                     fwd_reg, fwd_next;
    logic [1:0][mwm_pkg::MAG_W-1:0]                 pmax_reg, pmax_next;

    mwm_pkg::front_item_t item_reg, item_next;

    logic [mwm_pkg::SP_W-1:0] sum_q, dif_q, rot_ext;

    // The whole front moves together unless its last stage cannot be pushed.
    assign f_en     = !(vld_reg[STAGES-1] && q_status.full);
    assign s_tready = f_en;
    assign push     = vld_reg[STAGES-1] && !q_status.full;
    assign item     = item_reg;
    assign vld_next = {vld_reg[STAGES-2:0], s_tvalid};

    // Stage 1: rotation term in Q.12 and the two axis combinations.
    always_comb
    begin
        rot_next = mwm_pkg::ROT_W'(turn_rate)
                 * mwm_pkg::ROT_W'($signed({1'b0, rotation_gain}));
        sum_next = $signed({forward_speed[mwm_pkg::IN_W-1], forward_speed})
                 + $signed({lateral_speed[mwm_pkg::IN_W-1], lateral_speed});
        dif_next = $signed({forward_speed[mwm_pkg::IN_W-1], forward_speed})
                 - $signed({lateral_speed[mwm_pkg::IN_W-1], lateral_speed});
    end

    // Stage 2: the four wheel speeds in Q.12.
    always_comb
    begin
        sum_q = {{(mwm_pkg::SP_W - mwm_pkg::SUM_W - mwm_pkg::FRAC_BITS){sum_reg[mwm_pkg::SUM_W-1]}},
                 sum_reg, {mwm_pkg::FRAC_BITS{1'b0}}};
        dif_q = {{(mwm_pkg::SP_W - mwm_pkg::SUM_W - mwm_pkg::FRAC_BITS){dif_reg[mwm_pkg::SUM_W-1]}},
                 dif_reg, {mwm_pkg::FRAC_BITS{1'b0}}};
        rot_ext = {{(mwm_pkg::SP_W - mwm_pkg::ROT_W){rot_reg[mwm_pkg::ROT_W-1]}}, rot_reg};
        sp_next[0] = sum_q - rot_ext;
        sp_next[1] = dif_q - rot_ext;
        sp_next[2] = dif_q + rot_ext;
        sp_next[3] = sum_q + rot_ext;
    end

    // Stage 3: direction, truncated magnitude and pairwise peaks.
    always_comb
    begin
        for (int l = 0; l < mwm_pkg::WHEELS; l++)
        begin
            abs_sp[l]   = sp_reg[l][mwm_pkg::SP_W-1] ? (~sp_reg[l] + 1'b1) : sp_reg[l];
            mag_next[l] = abs_sp[l][mwm_pkg::FRAC_BITS+mwm_pkg::MAG_W-1:mwm_pkg::FRAC_BITS];
            fwd_next[l] = !sp_reg[l][mwm_pkg::SP_W-1] && (sp_reg[l] != '0);
        end
        pmax_next[0] = (mag_next[0] > mag_next[1]) ? mag_next[0] : mag_next[1];
        pmax_next[1] = (mag_next[2] > mag_next[3]) ? mag_next[2] : mag_next[3];
    end

    // Stage 4: overall peak and the scaling decision.
    always_comb
    begin
        item_next.mag   = mag_reg;
        item_next.fwd   = fwd_reg;
        item_next.peak  = (pmax_reg[0] > pmax_reg[1]) ? pmax_reg[0] : pmax_reg[1];
        item_next.scale = item_next.peak > mwm_pkg::MAG_W'(speed_limit);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (f_en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (f_en)
        begin
            rot_reg  <= rot_next;
            sum_reg  <= sum_next;
            dif_reg  <= dif_next;
            sp_reg   <= sp_next;
            mag_reg  <= mag_next;
            fwd_reg  <= fwd_next;
            pmax_reg <= pmax_next;
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// File: src/mwm_queue.sv
// Short register queue between the front and the back of the mixer.
// Depends on mwm_pkg and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_mixer_core_assert.svh"

module mwm_queue
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mwm_pkg::front_item_t   push_item,
    input  wire logic                   pop,
    output mwm_pkg::front_item_t        head_item,
    output mwm_pkg::queue_status_t      status
);

    mwm_pkg::front_item_t entry_reg [mwm_pkg::QUEUE_DEPTH];

    logic [mwm_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [mwm_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [mwm_pkg::QCNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == mwm_pkg::QPTR_W'(mwm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == mwm_pkg::QPTR_W'(mwm_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + mwm_pkg::QCNT_W'(push) - mwm_pkg::QCNT_W'(pop);
    end

    assign head_item    = entry_reg[rd_ptr_reg];
    assign status.valid = (count_reg != '0);
    assign status.full  = (count_reg == mwm_pkg::QCNT_W'(mwm_pkg::QUEUE_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // The front must hold off while the queue is full, the back while empty.
    `MWM_ASSERT_IMPLIES(a_no_push_when_full, push, !status.full)
    `MWM_ASSERT_IMPLIES(a_no_pop_when_empty, pop, status.valid)
    `MWM_ASSERT_ALWAYS(a_count_in_range, count_reg <= mwm_pkg::QCNT_W'(mwm_pkg::QUEUE_DEPTH))

endmodule

`default_nettype wire

// File: src/mwm_back.sv
// Back end: scales the wheel magnitudes to the limit with a pipelined
// restoring divider, one quotient bit per stage. Depends on mwm_pkg.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_mixer_core_assert.svh"

module mwm_back
(
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire mwm_pkg::queue_status_t                    q_status,
    input  wire mwm_pkg::front_item_t                      q_item,
    output logic                                           pop,
    input  wire logic [mwm_pkg::CFG_W-1:0]                 speed_limit,
    output logic                                           m_tvalid,
    input  wire logic                                      m_tready,
    output logic [mwm_pkg::WHEELS-1:0][mwm_pkg::QUO_W-1:0] mag,
    output logic [mwm_pkg::WHEELS-1:0]                     fwd
);

    localparam int STAGES    = mwm_pkg::QUO_W;
    localparam int MID       = STAGES / 2;
    localparam int MID_SHIFT = STAGES - MID;

    logic [STAGES:0] vld_reg, vld_next;
    logic            b_en;

    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DIV_W-1:0] rem_reg [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DIV_W-1:0] rem_next [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0] div_reg [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::MAG_W-1:0] div_next [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::QUO_W-1:0] quo_reg [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::QUO_W-1:0] quo_next [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0]                     fwd_reg [0:STAGES];
    logic [mwm_pkg::WHEELS-1:0]                     fwd_next [0:STAGES];

    // The back stalls as a whole only while its result is refused.
    assign b_en     = !(vld_reg[STAGES] && !m_tready);
    assign pop      = b_en && q_status.valid;
    assign vld_next = {vld_reg[STAGES-1:0], pop};

    assign m_tvalid = vld_reg[STAGES];
    assign mag      = quo_reg[STAGES];
    assign fwd      = fwd_reg[STAGES];

    // Entry stage: a scaled set divides mag*limit by the peak; an unscaled
    // one divides the magnitude by one, so the same divider serves both.
    always_comb
    begin
        for (int l = 0; l < mwm_pkg::WHEELS; l++)
        begin
            if (q_item.scale)
            begin
                rem_next[0][l] = mwm_pkg::DIV_W'(q_item.mag[l])
                               * mwm_pkg::DIV_W'(speed_limit);
                div_next[0][l] = q_item.peak;
            end
            else
            begin
                rem_next[0][l] = mwm_pkg::DIV_W'(q_item.mag[l]);
                div_next[0][l] = mwm_pkg::MAG_W'(1);
            end
        end
        quo_next[0] = '0;
        fwd_next[0] = q_item.fwd;
    end

    genvar k;
    generate
        for (k = 0; k < STAGES; k++)
        begin : g_div
            localparam int SHIFT = STAGES - 1 - k;
            logic [mwm_pkg::WHEELS-1:0][mwm_pkg::DIV_W-1:0] trial;

            always_comb
            begin
                for (int l = 0; l < mwm_pkg::WHEELS; l++)
                begin
                    trial[l] = mwm_pkg::DIV_W'(div_reg[k][l]) << SHIFT;
                    if (rem_reg[k][l] >= trial[l])
                    begin
                        rem_next[k+1][l] = rem_reg[k][l] - trial[l];
                        quo_next[k+1][l] = {quo_reg[k][l][mwm_pkg::QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k+1][l] = rem_reg[k][l];
                        quo_next[k+1][l] = {quo_reg[k][l][mwm_pkg::QUO_W-2:0], 1'b0};
                    end
                end
                div_next[k+1] = div_reg[k];
                fwd_next[k+1] = fwd_reg[k];
            end
        end

        for (k = 0; k <= STAGES; k++)
        begin : g_stage
            always_ff @(posedge clk)
            begin
                if (b_en)
                begin
                    rem_reg[k] <= rem_next[k];
                    div_reg[k] <= div_next[k];
                    quo_reg[k] <= quo_next[k];
                    fwd_reg[k] <= fwd_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (b_en)
        begin
            vld_reg <= vld_next;
        end
    end

    // The quotient must fit its bits, and the remainder must be below the
    // shifted divisor at the middle stage and below the divisor at the last.
    genvar a;
    generate
        for (a = 0; a < mwm_pkg::WHEELS; a++)
        begin : g_chk
            `MWM_ASSERT_IMPLIES(a_quotient_fits, vld_reg[0],
                (rem_reg[0][a] >> mwm_pkg::QUO_W) < mwm_pkg::DIV_W'(div_reg[0][a]))
            `MWM_ASSERT_IMPLIES(a_mid_remainder, vld_reg[MID],
                rem_reg[MID][a] < (mwm_pkg::DIV_W'(div_reg[MID][a]) << MID_SHIFT))
            `MWM_ASSERT_IMPLIES(a_final_remainder, vld_reg[STAGES],
                rem_reg[STAGES][a] < mwm_pkg::DIV_W'(div_reg[STAGES][a]))
        end
    endgenerate

endmodule

`default_nettype wire

// File: src/mecanum_wheel_mixer_core.sv
// Mecanum wheel mixer: inverse kinematics with proportional limiting.
// Top level holding the configuration registers; uses mwm_pkg, mwm_front,
// mwm_queue and mwm_back.
//
// Usage
//   A command (lateral, forward and turn speed) arrives on the s_ stream and
//   is taken on every transfer. Each command yields exactly one result on the
//   m_ stream: four wheel PWM magnitudes and four direction bits, in order.
//   Configuration must be written through cfg_wen / cfg_index / cfg_wdata
//   only while no command is in flight; the block itself does not enforce it.
// Throughput and pipeline
//   One command per cycle is sustained while m_tready stays high. A result
//   passes four front stages (rotation product, wheel sums, magnitude and
//   peak, limit compare), a queue entry, then the scaling multiply and a
//   16 stage restoring divider, one quotient bit per stage, whose last
//   stage is the output register.
// Reset
//   rst_n clears all pipeline valids and the queue; speed_limit returns to
//   100 and rotation_gain to 7620 (Q4.12).
// Stalls
//   When m_tready refuses a result the back holds as a whole; the four entry
//   queue keeps absorbing front results; s_tready falls only once it is full.
`timescale 1ns / 1ps
`default_nettype none

module mecanum_wheel_mixer_core
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Command stream
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // [15:0] lateral_speed, [31:16] forward_speed, [47:32] turn_rate
    input  wire logic [3*mwm_pkg::IN_W-1:0]          s_tdata,
    // Result stream
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [15:0] front_left_mag, [31:16] rear_left_mag, [47:32] front_right_mag,
    // [63:48] rear_right_mag, [64] front_left_fwd, [65] rear_left_fwd,
    // [66] front_right_fwd, [67] rear_right_fwd, [71:68] zero
    output logic [71:0]                              m_tdata,
    // Configuration write port
    input  wire logic                                cfg_wen,
    input  wire logic [mwm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [mwm_pkg::CFG_W-1:0]           cfg_wdata
);

    logic [mwm_pkg::CFG_W-1:0] speed_limit_reg;
    logic [mwm_pkg::CFG_W-1:0] rotation_gain_reg;

    mwm_pkg::queue_status_t q_status;
    mwm_pkg::front_item_t   front_item;
    mwm_pkg::front_item_t   head_item;
    logic                   push;
    logic                   pop;

    logic [mwm_pkg::WHEELS-1:0][mwm_pkg::QUO_W-1:0] wheel_mag;
    logic [mwm_pkg::WHEELS-1:0]                     wheel_fwd;

    // Register writes take effect at once; an index outside the list is
    // simply dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg   <= mwm_pkg::RESET_SPEED_LIMIT;
            rotation_gain_reg <= mwm_pkg::RESET_ROTATION_GAIN;
        end
        else if (cfg_wen)
        begin
            case (mwm_pkg::cfg_index_t'(cfg_index))
                mwm_pkg::REG_SPEED_LIMIT:   speed_limit_reg   <= cfg_wdata;
                mwm_pkg::REG_ROTATION_GAIN: rotation_gain_reg <= cfg_wdata;
                default:                    ;
            endcase
        end
    end

    // The front end works out speeds, directions and whether to scale.
    mwm_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .lateral_speed (s_tdata[mwm_pkg::IN_W-1:0]),
        .forward_speed (s_tdata[2*mwm_pkg::IN_W-1:mwm_pkg::IN_W]),
        .turn_rate     (s_tdata[3*mwm_pkg::IN_W-1:2*mwm_pkg::IN_W]),
        .speed_limit   (speed_limit_reg),
        .rotation_gain (rotation_gain_reg),
        .q_status      (q_status),
        .push          (push),
        .item          (front_item)
    );

    // The queue lets the front keep taking commands while the output stalls.
    mwm_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (pop),
        .head_item (head_item),
        .status    (q_status)
    );

    // The back end scales to the limit and holds the result register.
    mwm_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .q_item      (head_item),
        .pop         (pop),
        .speed_limit (speed_limit_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .mag         (wheel_mag),
        .fwd         (wheel_fwd)
    );

    // Wheel zero is the lowest lane in both the magnitude and direction groups.
    assign m_tdata = {4'b0000, wheel_fwd, wheel_mag};

endmodule

`default_nettype wire

// File: tb/mecanum_wheel_mixer_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mecanum wheel mixer: directed and random commands
// are checked against an in-bench model of the kinematics and of the limit scaling.
// Depends on mwm_pkg and mecanum_wheel_mixer_core only.

module mecanum_wheel_mixer_core_tb;

    import mwm_pkg::*;

    localparam int SETTINGS_RUN    = 9;
    localparam int ITEMS_PER_SET   = 110;
    localparam int FILL_ITEMS      = 60;
    localparam int LONG_HOLD       = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 40;
    localparam int REPORT_LIMIT    = 10;

    // One result of the mixer, laid out as the wheels are numbered.
    typedef struct packed {
        logic [3:0]       fwd;
        logic [3:0][15:0] mag;
    } wheel_set_t;

    // Holds the register copies, predicts each wheel set and compares the
    // transfers that leave the block against the predictions, in order.
    class wheel_set_checker;
        logic [15:0] speed_limit;
        logic [15:0] rotation_gain;
        wheel_set_t  awaited_wheel_sets[$];
        int          commands;
        int          wheel_sets;
        int          mismatches;
        string       wheel_name[4];

        function new();
            speed_limit   = RESET_SPEED_LIMIT;
            rotation_gain = RESET_ROTATION_GAIN;
            wheel_name    = '{"front_left", "rear_left", "front_right", "rear_right"};
        endfunction

        function void set_register(cfg_index_t idx, logic [15:0] value);
            case (idx)
                REG_SPEED_LIMIT:   speed_limit   = value;
                REG_ROTATION_GAIN: rotation_gain = value;
                default: ;
            endcase
        endfunction

        // Wheel speeds are held in Q.12 so the rotation term is exact.
        function wheel_set_t mix_wheels(logic [15:0] lat, logic [15:0] fwd_spd,
                                        logic [15:0] turn);
            longint     x, y, w, g, lim, rot, along, across, peak;
            longint     speed[4];
            longint     mag[4];
            wheel_set_t ws;
            x      = $signed(lat);
            y      = $signed(fwd_spd);
            w      = $signed(turn);
            g      = rotation_gain;
            lim    = speed_limit;
            rot    = w * g;
            along  = (y + x) << FRAC_BITS;
            across = (y - x) << FRAC_BITS;
            speed[0] = along - rot;
            speed[1] = across - rot;
            speed[2] = across + rot;
            speed[3] = along + rot;
            peak = 0;
            for (int i = 0; i < 4; i++)
            begin
                // Truncation toward zero: shift the absolute value.
                mag[i] = (speed[i] < 0 ? -speed[i] : speed[i]) >> FRAC_BITS;
                if (mag[i] > peak)
                    peak = mag[i];
            end
            for (int i = 0; i < 4; i++)
            begin
                if (peak > lim)
                    mag[i] = (mag[i] * lim) / peak;
                ws.mag[i] = 16'(mag[i]);
                ws.fwd[i] = speed[i] > 0;
            end
            return ws;
        endfunction

        function void note_command(logic [47:0] data);
            commands++;
            awaited_wheel_sets.push_back(mix_wheels(data[15:0], data[31:16], data[47:32]));
        endfunction

        function void compare(string what, logic [15:0] want, logic [15:0] got);
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Mismatch in wheel set %0d, %s: expected %0d, got %0d",
                             wheel_sets, what, want, got);
            end
        endfunction

        function void check_wheel_set(logic [71:0] data);
            wheel_set_t want;
            wheel_sets++;
            if (awaited_wheel_sets.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("Wheel set %0d arrived with none outstanding: %h",
                             wheel_sets, data);
                return;
            end
            want = awaited_wheel_sets.pop_front();
            for (int i = 0; i < 4; i++)
            begin
                compare({wheel_name[i], " magnitude"}, want.mag[i], data[16*i +: 16]);
                compare({wheel_name[i], " direction"}, want.fwd[i], data[64 + i]);
            end
            compare("padding", 16'd0, data[71:68]);
        endfunction

        function int pending();
            return awaited_wheel_sets.size();
        endfunction
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;
    logic        cfg_wen   = 1'b0;
    cfg_index_t  cfg_index = REG_SPEED_LIMIT;
    logic [15:0] cfg_wdata = '0;

    wheel_set_checker sb;

    // Sender pacing: bursts of back-to-back transfers separated by gaps,
    // unless a steady stretch is asked for.
    bit offering   = 1'b0;
    bit steady     = 1'b0;
    int burst_left = 0;

    // Receiver pattern state; hold_req asks the receiver for one long stall.
    logic hold_req  = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_cnt  = 0;
    int   rx_mode   = 0;
    int   rx_left   = 0;
    int   quiet_cycles = 0;

    mecanum_wheel_mixer_core uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Both streams are observed on the same edge at which the transfer
    // happens, so the values seen are those from before the edge. The
    // watchdog restarts on any transfer or register write.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_command(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_wheel_set(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
                quiet_cycles <= 0;
            else if (quiet_cycles == WATCHDOG_LIMIT)
            begin
                $display("Watchdog expired with %0d wheel sets outstanding", sb.pending());
                $display("TEST FAILED");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // The receiver picks a new pattern each time its countdown runs out: always
    // ready, coin toss, ready three times in four, or mostly stalled. A rising
    // hold_req overrides the pattern with one long stall.
    always @(posedge clk)
    begin
        hold_seen <= hold_req;
        if (rx_left == 0)
        begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(40, 300);
        end
        else
            rx_left <= rx_left - 1;

        if (hold_req && !hold_seen)
        begin
            hold_cnt <= LONG_HOLD;
            m_tready <= 1'b0;
        end
        else if (hold_cnt != 0)
        begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= $urandom_range(0, 1);
                2:       m_tready <= (rx_left % 4) != 0;
                default: m_tready <= $urandom_range(0, 3) == 0;
            endcase
        end
    end

    // Changes s_tvalid only when its value really changes, so that it never
    // gets two nonblocking updates in one time step.
    task automatic set_offer(input bit value);
        if (offering != value)
        begin
            s_tvalid <= value;
            offering = value;
        end
    endtask

    // Offers one command and returns at the edge of its transfer, with
    // tvalid still high so that the next command may follow at once.
    task automatic offer_command(input logic [15:0] lat, input logic [15:0] fwd_spd,
                                 input logic [15:0] turn);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (!steady)
                gap = $urandom_range(1, 8);
        end
        burst_left--;
        if (gap > 0)
        begin
            set_offer(1'b0);
            repeat (gap) @(posedge clk);
        end
        s_tdata <= {turn, fwd_spd, lat};
        set_offer(1'b1);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stops offering and waits until every predicted wheel set has come out.
    // The first edge lets the last transfer be noted before the count is read.
    task automatic await_idle();
        set_offer(1'b0);
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    // Writes both registers on consecutive edges; called only when idle.
    task automatic configure(input logic [15:0] limit, input logic [15:0] gain);
        cfg_wen   <= 1'b1;
        cfg_index <= REG_SPEED_LIMIT;
        cfg_wdata <= limit;
        @(posedge clk);
        cfg_index <= REG_ROTATION_GAIN;
        cfg_wdata <= gain;
        @(posedge clk);
        cfg_wen <= 1'b0;
        sb.set_register(REG_SPEED_LIMIT, limit);
        sb.set_register(REG_ROTATION_GAIN, gain);
    endtask

    // Speeds are drawn from the whole range, from small values that often
    // stay under the limit, from a middle band, and from the extremes.
    function automatic logic [15:0] pick_speed();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 16'($urandom);
        else if (roll < 75)
            return 16'(int'($urandom_range(0, 160)) - 80);
        else if (roll < 88)
            return 16'(int'($urandom_range(0, 4000)) - 2000);
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'h0001;
            default: return 16'hffff;
        endcase
    endfunction

    initial
    begin
        logic [15:0] limit_plan [SETTINGS_RUN];
        logic [15:0] gain_plan  [SETTINGS_RUN];
        bit          pass_ok;

        // Extremes first, then a mix of corner and ordinary settings, with the
        // values that reset gives second to last and a random one at the end.
        limit_plan = '{16'hffff, 16'd0, 16'd0, 16'hffff, 16'd1, 16'd0, 16'd300,
                       16'd100, 16'd0};
        gain_plan  = '{16'hffff, 16'd0, 16'd7620, 16'd0, 16'd4096, 16'd0, 16'd1,
                       16'd7620, 16'd0};
        limit_plan[5] = 16'($urandom);
        gain_plan[5]  = 16'($urandom);
        limit_plan[8] = 16'($urandom_range(50, 2000));
        gain_plan[8]  = 16'($urandom);

        sb = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed commands under the reset settings (limit 100, gain 7620).
        offer_command(16'd0, 16'd0, 16'd0);              // every wheel exactly zero
        offer_command(16'h7fff, 16'h7fff, 16'h7fff);     // all fields at their maximum
        offer_command(16'h8000, 16'h8000, 16'h8000);     // all fields at their minimum
        offer_command(16'h7fff, 16'h8000, 16'd0);
        offer_command(16'h8000, 16'h7fff, 16'h7fff);
        offer_command(16'd0, 16'd2, 16'd1);              // small positive fraction
        offer_command(16'd0, 16'd1, 16'd1);              // small negative fraction
        offer_command(16'd5, 16'd5, 16'd0);              // two wheels exactly zero
        offer_command(16'd10, 16'd20, 16'd3);            // well under the limit
        offer_command(16'd60, 16'd40, 16'd0);            // peak equal to the limit
        offer_command(16'd61, 16'd40, 16'd0);            // peak one above the limit
        offer_command(16'd0, 16'd0, 16'hffff);
        offer_command(16'hffff, 16'hffff, 16'hffff);
        offer_command(16'd1, 16'd0, 16'd0);
        offer_command(16'd0, 16'hffff, 16'd0);
        offer_command(16'd0, 16'd0, 16'h7fff);
        offer_command(16'd0, 16'd0, 16'h8000);
        await_idle();

        for (int p = 0; p < SETTINGS_RUN; p++)
        begin
            configure(limit_plan[p], gain_plan[p]);
            steady = (p % 3 == 0);
            for (int n = 0; n < ITEMS_PER_SET; n++)
            begin
                // Halfway through each setting the sender pauses until the
                // block has delivered everything it holds.
                if (n == ITEMS_PER_SET / 2)
                    await_idle();
                // Once, the receiver stalls for a long stretch while commands
                // keep coming, so the queue fills and s_tready falls.
                if (p == 3 && n == 10)
                begin
                    hold_req <= 1'b1;
                    steady = 1'b1;
                    for (int k = 0; k < FILL_ITEMS; k++)
                        offer_command(pick_speed(), pick_speed(), pick_speed());
                    hold_req <= 1'b0;
                    steady = 1'b0;
                end
                offer_command(pick_speed(), pick_speed(), pick_speed());
            end
            await_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        pass_ok = (sb.mismatches == 0) && (sb.pending() == 0);
        if (sb.pending() != 0)
            $display("%0d predicted wheel sets never arrived", sb.pending());
        $display("Checked %0d commands and %0d wheel sets over %0d register settings,",
                 sb.commands, sb.wheel_sets, SETTINGS_RUN + 1);
        $display("with zero and full-scale limits and gains, sender gaps and a long output stall.");
        if (pass_ok)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
